// ===== design/nrcp_pkg.sv =====
// Shared types and constants for the nested region cycle profiler.
// No dependencies; imported by every other source file of the project.

package nrcp_pkg;

    localparam int ANCHOR_IDX_W = 12;
    localparam int CYCLE_W      = 64;

    typedef enum logic [1:0] {
        CMD_ENTER = 2'd0,
        CMD_EXIT  = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_IDX,
        S_EXEC,
        S_EXIT2
    } t_state;

    typedef struct packed {
        t_cmd                    command;
        logic [ANCHOR_IDX_W-1:0] anchor_index;
        logic [CYCLE_W-1:0]      timestamp;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [CYCLE_W-1:0] inclusive_cycles;
        logic [CYCLE_W-1:0] children_cycles;
        logic [CYCLE_W-1:0] root_cycles;
        logic [CYCLE_W-1:0] self_cycles;
        logic [CYCLE_W-1:0] hit_count;
    } t_out_item;

    // One anchor table word.
    typedef struct packed {
        logic [CYCLE_W-1:0] inclusive;
        logic [CYCLE_W-1:0] children;
        logic [CYCLE_W-1:0] root;
        logic [CYCLE_W-1:0] hits;
    } t_anchor;

endpackage

// ===== design/nrcp_index_wrap.sv =====
// Reduces the 12-bit anchor index modulo ANCHOR_COUNT behind one register stage.
// Depends on nrcp_pkg.

module nrcp_index_wrap
    import nrcp_pkg::*;
#(
    parameter int ANCHOR_COUNT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [ANCHOR_IDX_W-1:0]         i_raw,
    output logic [$clog2(ANCHOR_COUNT)-1:0] o_index
);

    localparam int AW    = $clog2(ANCHOR_COUNT);
    // Reciprocal exact for every 12-bit dividend.
    localparam int SHIFT = ANCHOR_IDX_W + AW;
    localparam int RECIP = (2 ** SHIFT + ANCHOR_COUNT - 1) / ANCHOR_COUNT;

    logic [ANCHOR_IDX_W-1:0] r_raw;
    logic [ANCHOR_IDX_W-1:0] r_quot;
    logic [31:0]             prod;
    logic [31:0]             rem;

    assign prod = 32'(i_raw) * 32'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_raw  <= i_raw;
            r_quot <= ANCHOR_IDX_W'(prod >> SHIFT);
        end
    end

    assign rem     = 32'(r_raw) - 32'(r_quot) * 32'(ANCHOR_COUNT);
    assign o_index = AW'(rem);

endmodule

// ===== design/nested_region_cycle_profiler.sv =====
// Hierarchical region profiler: anchor table and open-region stack, both in synchronous RAM.
// Depends on nrcp_pkg and nrcp_index_wrap.
//
// Takes one command beat at a time: enter opens a region on an anchor, exit closes the
// innermost region and charges the elapsed cycles (mod 2^64) to the anchor and its
// parent, read returns an anchor's totals plus self time. Every beat gives exactly one
// result beat. After reset a clearing pass zeroes all ANCHOR_COUNT anchor table entries,
// during which o_in_stall stays high. Enter and read pass from acceptance through index
// reduction and table read (S_IDX) to the step that loads the result (S_EXEC); exit then
// writes the parent back in S_EXIT2, as anchor and parent are two read-modify-writes
// through the one read port of the anchor table (skipped when a region nests directly in
// the same anchor). A finished result waits in the output register while the next beat is
// accepted; the block only holds in its last step if that register is still full. Status:
// done, enter ignored on a full stack, exit ignored on an empty stack.

module nested_region_cycle_profiler
    import nrcp_pkg::*;
#(
    parameter int ANCHOR_COUNT = 4096,
    parameter int STACK_DEPTH  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(ANCHOR_COUNT);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);

    typedef struct packed {
        logic [AW-1:0]      anchor;
        logic [AW-1:0]      parent;
        logic [CYCLE_W-1:0] start;
        logic [CYCLE_W-1:0] saved_root;
    } t_frame;

    // Memories
    t_anchor r_anchor_mem [ANCHOR_COUNT];
    t_frame  r_frame_mem  [STACK_DEPTH];
    t_anchor r_anc_q;
    t_frame  r_frm_q;

    // Control state
    t_state        r_state, n_state;
    logic [LW-1:0] r_level, n_level;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_clr;
    logic          r_out_valid;

    // Item context
    t_cmd               r_cmd;
    logic [CYCLE_W-1:0] r_ts;
    logic [CYCLE_W-1:0] r_elapsed;
    logic [AW-1:0]      r_idx;
    t_out_item          r_out;

    logic          in_acc;
    logic          out_free;
    logic          out_load;
    t_out_item     out_next;
    logic [AW-1:0] w_idx;
    logic          stack_full;
    logic          stack_empty;
    logic          same_anchor;
    logic          exec_go;

    logic          anc_rd_en;
    logic [AW-1:0] anc_rd_addr;
    logic          anc_wr_en;
    logic [AW-1:0] anc_wr_addr;
    t_anchor       anc_wr_data;
    logic          frm_wr_en;
    t_frame        frm_wr_data;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign stack_full  = (r_level == LW'(STACK_DEPTH));
    assign stack_empty = (r_level == '0);
    assign same_anchor = (r_frm_q.anchor == r_frm_q.parent);

    // An exit that moves on to the parent needs no output slot yet.
    assign exec_go = (r_cmd == CMD_EXIT && !stack_empty && !same_anchor) || out_free;

    nrcp_index_wrap #(
        .ANCHOR_COUNT(ANCHOR_COUNT)
    ) u_wrap (
        .i_clk   (i_clk),
        .i_load  (in_acc),
        .i_raw   (i_in_data.anchor_index),
        .o_index (w_idx)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(ANCHOR_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (exec_go) begin
                    if (r_cmd == CMD_EXIT && !stack_empty && !same_anchor) begin
                        n_state = S_EXIT2;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EXIT2: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory controls, stack updates and result
    always_comb begin
        anc_rd_en   = 1'b0;
        anc_rd_addr = r_idx;
        anc_wr_en   = 1'b0;
        anc_wr_addr = r_frm_q.anchor;
        anc_wr_data = r_anc_q;
        frm_wr_en   = 1'b0;
        frm_wr_data = '{anchor: r_idx, parent: r_cur, start: r_ts, saved_root: r_anc_q.root};
        n_level     = r_level;
        n_cur       = r_cur;
        out_load    = 1'b0;
        out_next    = '0;
        out_next.status = ST_DONE;

        case (r_state)
            S_CLEAR: begin
                anc_wr_en   = 1'b1;
                anc_wr_addr = r_clr;
                anc_wr_data = '0;
            end
            S_IDX: begin
                anc_rd_en   = 1'b1;
                anc_rd_addr = (r_cmd == CMD_EXIT) ? r_frm_q.anchor : w_idx;
            end
            S_EXEC: begin
                if (exec_go) begin
                    case (r_cmd)
                        CMD_ENTER: begin
                            out_load = 1'b1;
                            if (stack_full) begin
                                out_next.status = ST_FULL;
                            end else begin
                                frm_wr_en = 1'b1;
                                n_level   = r_level + LW'(1);
                                n_cur     = r_idx;
                            end
                        end
                        CMD_EXIT: begin
                            if (stack_empty) begin
                                out_load        = 1'b1;
                                out_next.status = ST_EMPTY;
                            end else begin
                                anc_wr_en             = 1'b1;
                                anc_wr_addr           = r_frm_q.anchor;
                                anc_wr_data.inclusive = r_anc_q.inclusive + r_elapsed;
                                anc_wr_data.root      = r_frm_q.saved_root + r_elapsed;
                                anc_wr_data.hits      = r_anc_q.hits + CYCLE_W'(1);
                                // recursion on one anchor: parent total lands in the same word
                                if (same_anchor) begin
                                    anc_wr_data.children = r_anc_q.children + r_elapsed;
                                    out_load = 1'b1;
                                end else begin
                                    anc_rd_en   = 1'b1;
                                    anc_rd_addr = r_frm_q.parent;
                                end
                                n_level = r_level - LW'(1);
                                n_cur   = r_frm_q.parent;
                            end
                        end
                        CMD_READ: begin
                            out_load                  = 1'b1;
                            out_next.inclusive_cycles = r_anc_q.inclusive;
                            out_next.children_cycles  = r_anc_q.children;
                            out_next.root_cycles      = r_anc_q.root;
                            out_next.self_cycles      = r_anc_q.inclusive - r_anc_q.children;
                            out_next.hit_count        = r_anc_q.hits;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_EXIT2: begin
                if (out_free) begin
                    anc_wr_en            = 1'b1;
                    anc_wr_addr          = r_frm_q.parent;
                    anc_wr_data.children = r_anc_q.children + r_elapsed;
                    out_load             = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Anchor table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (anc_wr_en) begin
            r_anchor_mem[anc_wr_addr] <= anc_wr_data;
        end
        if (anc_rd_en) begin
            r_anc_q <= r_anchor_mem[anc_rd_addr];
        end
    end

    // Frame stack: top frame read on acceptance, push written at the current level
    always_ff @(posedge i_clk) begin
        if (frm_wr_en) begin
            r_frame_mem[SW'(r_level)] <= frm_wr_data;
        end
        if (in_acc) begin
            r_frm_q <= r_frame_mem[SW'(r_level - LW'(1))];
        end
    end

    // Item context
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_in_data.command;
            r_ts  <= i_in_data.timestamp;
        end
        if (r_state == S_IDX) begin
            r_idx     <= w_idx;
            r_elapsed <= r_ts - r_frm_q.start;
        end
        if (out_load) begin
            r_out <= out_next;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_level     <= '0;
            r_cur       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_cur       <= n_cur;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_level_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level != $past(r_level)) |->
            (r_level == $past(r_level) + LW'(1) || r_level == $past(r_level) - LW'(1)))
        else $error("stack level moved by more than one frame");

    a_anchor_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (anc_wr_en && anc_rd_en) |-> (anc_wr_addr != anc_rd_addr))
        else $error("anchor table read and written at the same entry");
`endif

endmodule

// ===== dv/nrcp_profile_checker.sv =====
// Checker for the nested region cycle profiler: watches both channels, keeps its own
// anchor table and region stack, and compares every result beat with its prediction.
// Depends on nrcp_pkg.

module nrcp_profile_checker
    import nrcp_pkg::*;
#(
    parameter int ANCHOR_COUNT = 4096,
    parameter int STACK_DEPTH  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted anchor table
    logic [CYCLE_W-1:0]      incl_tot  [ANCHOR_COUNT];
    logic [CYCLE_W-1:0]      child_tot [ANCHOR_COUNT];
    logic [CYCLE_W-1:0]      root_tot  [ANCHOR_COUNT];
    logic [CYCLE_W-1:0]      hit_tot   [ANCHOR_COUNT];

    // Predicted region stack
    logic [ANCHOR_IDX_W-1:0] frm_anchor [STACK_DEPTH];
    logic [ANCHOR_IDX_W-1:0] frm_parent [STACK_DEPTH];
    logic [CYCLE_W-1:0]      frm_start  [STACK_DEPTH];
    logic [CYCLE_W-1:0]      frm_root   [STACK_DEPTH];
    int                      depth_now   = 0;
    logic [ANCHOR_IDX_W-1:0] open_anchor = '0;

    t_out_item answer_due_q[$];
    int        fail_count = 0;

    function automatic t_out_item predict_profile(input t_in_item beat);
        t_out_item          ans;
        int                 idx;
        int                 a;
        int                 p;
        int                 lvl;
        logic [CYCLE_W-1:0] span;
        ans        = '0;
        ans.status = ST_DONE;
        idx        = int'(beat.anchor_index) % ANCHOR_COUNT;
        case (beat.command)
            CMD_ENTER: begin
                if (depth_now >= STACK_DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    frm_anchor[depth_now] = ANCHOR_IDX_W'(idx);
                    frm_parent[depth_now] = open_anchor;
                    frm_start[depth_now]  = beat.timestamp;
                    frm_root[depth_now]   = root_tot[idx];
                    depth_now             = depth_now + 1;
                    open_anchor           = ANCHOR_IDX_W'(idx);
                end
            end
            CMD_EXIT: begin
                if (depth_now == 0) begin
                    ans.status = ST_EMPTY;
                end else begin
                    lvl          = depth_now - 1;
                    a            = int'(frm_anchor[lvl]) % ANCHOR_COUNT;
                    p            = int'(frm_parent[lvl]) % ANCHOR_COUNT;
                    span         = beat.timestamp - frm_start[lvl];
                    incl_tot[a]  = incl_tot[a] + span;
                    child_tot[p] = child_tot[p] + span;
                    // recursion counted once: saved total from the outer entry
                    root_tot[a]  = frm_root[lvl] + span;
                    hit_tot[a]   = hit_tot[a] + 1;
                    open_anchor  = frm_parent[lvl];
                    depth_now    = lvl;
                end
            end
            CMD_READ: begin
                ans.inclusive_cycles = incl_tot[idx];
                ans.children_cycles  = child_tot[idx];
                ans.root_cycles      = root_tot[idx];
                ans.self_cycles      = incl_tot[idx] - child_tot[idx];
                ans.hit_count        = hit_tot[idx];
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic check_field(input string tag, input logic [CYCLE_W-1:0] want,
                               input logic [CYCLE_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s expected %h, actual %h", $time, tag, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < ANCHOR_COUNT; k++) begin
                incl_tot[k]  = '0;
                child_tot[k] = '0;
                root_tot[k]  = '0;
                hit_tot[k]   = '0;
            end
            depth_now   = 0;
            open_anchor = '0;
            answer_due_q.delete();
        end else begin
            // result side first, so a beat can never match its own prediction
            if (i_out_valid && !i_out_stall) begin
                if (answer_due_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with none pending, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want = answer_due_q.pop_front();
                    check_field("status", CYCLE_W'(want.status), CYCLE_W'(i_out_data.status));
                    check_field("inclusive_cycles", want.inclusive_cycles,
                                i_out_data.inclusive_cycles);
                    check_field("children_cycles", want.children_cycles,
                                i_out_data.children_cycles);
                    check_field("root_cycles", want.root_cycles, i_out_data.root_cycles);
                    check_field("self_cycles", want.self_cycles, i_out_data.self_cycles);
                    check_field("hit_count", want.hit_count, i_out_data.hit_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                answer_due_q.push_back(predict_profile(i_in_data));
            end
        end
        o_pending    <= answer_due_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== dv/tb.sv =====
// Top of the profiler testbench: clock, reset, command stimulus and result back-pressure.
// Depends on nrcp_pkg, nested_region_cycle_profiler and nrcp_profile_checker.

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nrcp_pkg::*;

    localparam int ANCHOR_COUNT = 4096;
    localparam int STACK_DEPTH  = 64;

    // Command code the block must treat as a no-op
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Run length. Beats of the spare command are not counted.
    localparam int TOTAL_BEATS  = 925;
    localparam int QUIET_FROM   = TOTAL_BEATS - 120;  // no idling on either side after this
    localparam int DRAIN_CYCLES = 16;
    // Covers the clearing pass plus all beats of the run, with a wide margin
    localparam int CYCLE_LIMIT  = 400_000;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending;

    nested_region_cycle_profiler #(
        .ANCHOR_COUNT (ANCHOR_COUNT),
        .STACK_DEPTH  (STACK_DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    nrcp_profile_checker #(
        .ANCHOR_COUNT (ANCHOR_COUNT),
        .STACK_DEPTH  (STACK_DEPTH)
    ) profile_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Result side back-pressure. Each stall level is held for a random
    // stretch; a stall burst is always followed by a free stretch, and a
    // free stretch by either another free one or a burst.
    // ------------------------------------------------------------------
    logic rx_idle_en = 1'b1;
    int   hold_left  = 0;

    always @(posedge clk) begin
        if (!rx_idle_en) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (out_stall || $urandom_range(0, 1) == 0) begin
            out_stall <= 1'b0;
            hold_left <= $urandom_range(0, 59);
        end else begin
            out_stall <= 1'b1;
            hold_left <= $urandom_range(0, 17);
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    logic                    tx_idle_en = 1'b1;
    int                      open_depth = 0;   // mirror of the block's stack level
    int                      beats_sent = 0;
    logic [CYCLE_W-1:0]      prof_clock = '0;  // counter the regions are timed by, advanced on each stamp
    logic [ANCHOR_IDX_W-1:0] hot_set [6];      // small set so nesting and recursion repeat

    function automatic logic [CYCLE_W-1:0] any_stamp();
        return {$urandom, $urandom};
    endfunction

    // Mostly small steps; now and then a huge jump so elapsed times wrap
    function automatic logic [CYCLE_W-1:0] next_stamp();
        if ($urandom_range(0, 49) == 0)
            prof_clock = prof_clock + any_stamp();
        else
            prof_clock = prof_clock + $urandom_range(1, 2000);
        return prof_clock;
    endfunction

    function automatic logic [ANCHOR_IDX_W-1:0] pick_anchor();
        if ($urandom_range(0, 4) == 0)
            return ANCHOR_IDX_W'($urandom);
        return hot_set[$urandom_range(0, 5)];
    endfunction

    // One beat: optional idle burst, then hold valid until the block takes it.
    // Stall is sampled just after the edge, i.e. the value the edge saw.
    task automatic issue_beat(input t_cmd cmd, input logic [ANCHOR_IDX_W-1:0] anchor,
                              input logic [CYCLE_W-1:0] stamp);
        t_in_item beat;
        beat.command      = cmd;
        beat.anchor_index = anchor;
        beat.timestamp    = stamp;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (cmd == CMD_ENTER && open_depth < STACK_DEPTH)
            open_depth++;
        else if (cmd == CMD_EXIT && open_depth > 0)
            open_depth--;
        if (cmd != CMD_SPARE)
            beats_sent++;
    endtask

    task automatic open_region(input logic [ANCHOR_IDX_W-1:0] anchor);
        issue_beat(CMD_ENTER, anchor, next_stamp());
    endtask

    // anchor field is don't-care on exit, so it carries noise
    task automatic close_region();
        issue_beat(CMD_EXIT, ANCHOR_IDX_W'($urandom), next_stamp());
    endtask

    // Fill the stack, push a few more against the full stack, read, unwind,
    // then one exit too many
    task automatic deep_dive();
        repeat (STACK_DEPTH - open_depth + $urandom_range(1, 3)) open_region(pick_anchor());
        repeat (2) issue_beat(CMD_READ, pick_anchor(), any_stamp());
        while (open_depth > 0) close_region();
        close_region();
    endtask

    initial begin
        int pick;
        int base;
        int step;
        hot_set[0] = '0;
        hot_set[1] = '1;
        for (int k = 2; k < 6; k++) hot_set[k] = ANCHOR_IDX_W'($urandom);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        issue_beat(CMD_READ, '0, '0);                        // table clear after reset
        issue_beat(CMD_EXIT, '0, 64'd77);                    // exit with nothing open
        issue_beat(t_cmd'(CMD_SPARE), '1, '1);               // unused command
        issue_beat(CMD_ENTER, '1, 64'hFFFF_FFFF_FFFF_FFF0);  // top anchor, near counter wrap
        issue_beat(CMD_ENTER, '1, 64'hFFFF_FFFF_FFFF_FFF8);  // same anchor nested in itself
        issue_beat(CMD_EXIT, '0, 64'h4);                     // elapsed wraps through zero
        issue_beat(CMD_EXIT, '1, 64'h10);
        issue_beat(CMD_READ, '1, '1);                        // root total counts recursion once
        issue_beat(CMD_READ, '0, '0);                        // children total holds the outer region's time
        issue_beat(CMD_ENTER, 12'd1, 64'd100);
        issue_beat(CMD_ENTER, 12'd2, 64'd150);
        issue_beat(CMD_READ, 12'd2, 64'd5);                  // read while the region is open
        issue_beat(CMD_EXIT, 12'hABC, 64'd180);
        issue_beat(CMD_EXIT, '0, 64'd300);
        issue_beat(CMD_READ, 12'd1, '0);
        issue_beat(CMD_READ, 12'd2, '0);
        issue_beat(CMD_ENTER, '0, '0);                       // root anchor as a region
        issue_beat(CMD_EXIT, '0, '1);                        // largest elapsed
        issue_beat(CMD_READ, '0, '0);                        // self time is inclusive minus children
        issue_beat(CMD_EXIT, '1, '0);                        // empty again

        // --- random part ---
        prof_clock = any_stamp();
        deep_dive();
        while (beats_sent < TOTAL_BEATS) begin
            if (beats_sent >= QUIET_FROM) begin
                tx_idle_en = 1'b0;
                rx_idle_en <= 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                deep_dive();
            end else if (pick < 70) begin
                // well-formed nest above whatever is already open, reads mixed in
                base = open_depth;
                repeat ($urandom_range(2, 24)) begin
                    step = $urandom_range(0, 9);
                    if (step < 2)
                        issue_beat(CMD_READ, pick_anchor(), any_stamp());
                    else if (step < 6 && open_depth < STACK_DEPTH)
                        open_region(pick_anchor());
                    else if (open_depth > base)
                        close_region();
                end
                while (open_depth > base) close_region();
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) issue_beat(CMD_READ, pick_anchor(), any_stamp());
            end else if (pick < 96) begin
                // noise: any command, any anchor, any timestamp
                issue_beat(t_cmd'(2'($urandom_range(0, 3))), ANCHOR_IDX_W'($urandom),
                           any_stamp());
            end else if (pick < 98) begin
                close_region();                              // stray exit, maybe on empty
            end else begin
                issue_beat(t_cmd'(CMD_SPARE), ANCHOR_IDX_W'($urandom), any_stamp());
            end
        end
        in_valid <= 1'b0;

        // pending is registered in the checker, so it lags the queue it reports
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    int cycle_count;

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== nested_region_cycle_profiler.f =====
design/nrcp_pkg.sv
design/nrcp_index_wrap.sv
design/nested_region_cycle_profiler.sv
dv/nrcp_profile_checker.sv
dv/tb.sv
